FILE: design/rtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_pkg
// shared widths, constants and the pt100 calibration table
// ----------------------------------------------------------------------------
package rtd_pkg;

   localparam int CODE_W        = 16;
   localparam int GAIN_W        = 16;
   localparam int DIFF_W        = 15;
   localparam int PROD_W        = DIFF_W + GAIN_W;
   localparam int SCALE_W       = 10;
   localparam int WIDE_W        = PROD_W + SCALE_W;
   localparam int RES_SHIFT     = 23;
   localparam int RES_W         = 18;
   localparam int MOHM_W        = 17;
   localparam int CELSIUS_W     = 6;
   localparam int SPAN_W        = 11;
   localparam int TEMP_W        = 14;
   localparam int STORED_POINTS = 11;

   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd49600;
   localparam logic [SCALE_W-1:0] MOHM_PER_OHM = 10'd1000;
   localparam logic [TEMP_W-1:0]  TEMP_MAX     = 14'h3FFF;

   typedef logic [MOHM_W-1:0]    mohm_type;
   typedef logic [CELSIUS_W-1:0] celsius_type;

   // pt100 resistance in milliohms, 0 C to 50 C in 5 C steps
   localparam mohm_type PT_MOHM [STORED_POINTS] = '{
      17'd100000, 17'd101953, 17'd103903, 17'd105849, 17'd107794, 17'd109735,
      17'd111673, 17'd113608, 17'd115541, 17'd117470, 17'd119397
   };

   localparam celsius_type PT_CELSIUS [STORED_POINTS] = '{
      6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40, 6'd45, 6'd50
   };

endpackage

FILE: design/rtd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_div
// pipelined restoring divider, one quotient bit per stage, payload rides along
// ----------------------------------------------------------------------------
module rtd_div #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 12,
   parameter int QUO_W = 14,
   parameter int PAY_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_payload,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [QUO_W-1:0] out_quot,
   output logic [PAY_W-1:0] out_payload
);

   logic             v_ff   [QUO_W];
   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [PAY_W-1:0] pay_ff [QUO_W];
   logic             rdy    [QUO_W+1];

   assign rdy[QUO_W] = out_ready;
   assign in_ready   = rdy[0];

   genvar s;
   generate
      for (s = 0; s < QUO_W; s++) begin : g_stage
         localparam int K = QUO_W - 1 - s;
         logic             src_v;
         logic [NUM_W-1:0] src_rem;
         logic [DEN_W-1:0] src_den;
         logic [QUO_W-1:0] src_quo;
         logic [PAY_W-1:0] src_pay;
         logic [NUM_W-1:0] shifted;
         logic             geq;
         logic [NUM_W-1:0] rem_in;
         logic [QUO_W-1:0] quo_in;

         if (s == 0) begin : g_head
            assign src_v   = in_valid;
            assign src_rem = in_num;
            assign src_den = in_den;
            assign src_quo = '0;
            assign src_pay = in_payload;
         end else begin : g_body
            assign src_v   = v_ff[s-1];
            assign src_rem = rem_ff[s-1];
            assign src_den = den_ff[s-1];
            assign src_quo = quo_ff[s-1];
            assign src_pay = pay_ff[s-1];
         end

         assign rdy[s]  = !v_ff[s] || rdy[s+1];
         assign shifted = NUM_W'(src_den) << K;
         assign geq     = (src_rem >= shifted);
         assign rem_in  = geq ? (src_rem - shifted) : src_rem;
         assign quo_in  = src_quo | (QUO_W'(geq) << K);

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (rdy[s]) begin
               v_ff[s] <= src_v;
            end
            if (rdy[s]) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= src_den;
               quo_ff[s] <= quo_in;
               pay_ff[s] <= src_pay;
            end
         end
      end
   endgenerate

   assign out_valid   = v_ff[QUO_W-1];
   assign out_quot    = quo_ff[QUO_W-1];
   assign out_payload = pay_ff[QUO_W-1];

endmodule

FILE: design/rtd_code_to_temperature.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_code_to_temperature
// adc code to pt100 resistance, table segment search, linear interpolation
// ----------------------------------------------------------------------------
// pipeline: stages 1 to 4, then one divider stage per quotient bit, then the output register
// throughput: one word per cycle while rsp_tready is high; the divider spends one stage per quotient bit
// every stage stalls only when it and its successor are both full and the successor stalls, so bubbles are squeezed out
// reset clears all valid bits and loads ref_over_gain_q8 with 49600 (193.75 ohm)
// ----------------------------------------------------------------------------
module rtd_code_to_temperature #(
   parameter int TABLE_POINTS   = 11,
   parameter int TEMP_FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   // input words
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rtd_pkg::CODE_W-1:0]  req_tdata,     // [15:0] sample_code
   // result words
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,     // [13:0] temperature_q8, [15:14] zero
   output logic                        rsp_tuser,     // [0] in_range
   // ref_over_gain_q8 register
   input  logic                        csr_wr_en,
   input  logic [rtd_pkg::GAIN_W-1:0]  csr_wr_data
);

   import rtd_pkg::*;

   // segments in use and datapath widths that follow from the fraction bits
   localparam int USED   = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS : TABLE_POINTS;
   localparam int QUO_W  = CELSIUS_W + TEMP_FRAC_BITS;      // delta and upper temp
   localparam int NUM0_W = QUO_W + SPAN_W;                  // dt << F times distance
   localparam int NUM_W  = NUM0_W + 2;                      // 2*num + span
   localparam int DEN_W  = SPAN_W + 1;                      // 2*span
   localparam int PAY_W  = QUO_W + 1;                       // upper temp and hit
   localparam int TW     = (QUO_W > TEMP_W) ? QUO_W : TEMP_W;

   // configuration register
   logic [GAIN_W-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wr_en) begin
         gain_ff <= csr_wr_data;
      end
   end

   // stage enables: a stage loads when it is empty or its successor loads
   logic s1_en, s2_en, s3_en, s4_en, out_en;
   logic div_in_ready, div_out_valid;

   // ---------------------------------------------------------------------
   // stage 1: offset removal and code times gain
   // ---------------------------------------------------------------------
   logic              s1_v_ff;
   logic              s1_pos_ff, s1_pos_in;
   logic [PROD_W-1:0] s1_prod_ff, s1_prod_in;

   // code above midpoint means positive resistance; the low bits are then d
   assign s1_pos_in  = req_tdata[CODE_W-1] && (req_tdata[CODE_W-2:0] != '0);
   assign s1_prod_in = PROD_W'(req_tdata[DIFF_W-1:0]) * PROD_W'(gain_ff);
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= req_tvalid;
      end
      if (s1_en) begin
         s1_pos_ff  <= s1_pos_in;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 2: scale to milliohms, drop the q8 and 2^15 fraction bits
   // ---------------------------------------------------------------------
   logic              s2_v_ff;
   logic              s2_pos_ff;
   logic [WIDE_W-1:0] s2_wide;
   logic [RES_W-1:0]  s2_res_ff, s2_res_in;

   assign s2_wide   = WIDE_W'(s1_prod_ff) * WIDE_W'(MOHM_PER_OHM);
   assign s2_res_in = s2_wide[RES_SHIFT +: RES_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_en) begin
         s2_pos_ff <= s1_pos_ff;
         s2_res_ff <= s2_res_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 3: parallel segment compare, lower <= r < upper
   // ---------------------------------------------------------------------
   logic                 s3_v_ff;
   logic                 s3_hit_ff, s3_hit_in;
   logic [SPAN_W-1:0]    s3_dist_ff, s3_dist_in;     // upper - r
   logic [SPAN_W-1:0]    s3_span_ff, s3_span_in;     // upper - lower
   logic [CELSIUS_W-1:0] s3_dt_ff, s3_dt_in;
   logic [CELSIUS_W-1:0] s3_tu_ff, s3_tu_in;
   logic [RES_W-1:0]     s3_dist_w;

   always_comb begin
      s3_hit_in  = 1'b0;
      s3_dist_w  = '0;
      s3_span_in = '0;
      s3_dt_in   = '0;
      s3_tu_in   = '0;
      for (int i = 0; i < STORED_POINTS - 1; i++) begin
         if ((i + 1 < USED) && !s3_hit_in && s2_pos_ff &&
             (s2_res_ff >= RES_W'(PT_MOHM[i])) && (s2_res_ff < RES_W'(PT_MOHM[i+1]))) begin
            s3_hit_in  = 1'b1;
            s3_dist_w  = RES_W'(PT_MOHM[i+1]) - s2_res_ff;
            s3_span_in = SPAN_W'(PT_MOHM[i+1] - PT_MOHM[i]);
            s3_dt_in   = PT_CELSIUS[i+1] - PT_CELSIUS[i];
            s3_tu_in   = PT_CELSIUS[i+1];
         end
      end
   end

   assign s3_dist_in = s3_dist_w[SPAN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (s3_en) begin
         s3_hit_ff  <= s3_hit_in;
         s3_dist_ff <= s3_dist_in;
         s3_span_ff <= s3_span_in;
         s3_dt_ff   <= s3_dt_in;
         s3_tu_ff   <= s3_tu_in;
      end
   end

   // ---------------------------------------------------------------------
   // stage 4: numerator (dt << F) * (upper - r), doubled plus span for rounding
   // ---------------------------------------------------------------------
   logic              s4_v_ff;
   logic [QUO_W-1:0]  s4_dt_sh;
   logic [NUM0_W-1:0] s4_num0;
   logic [NUM_W-1:0]  s4_num_ff, s4_num_in;
   logic [DEN_W-1:0]  s4_den_ff, s4_den_in;
   logic [PAY_W-1:0]  s4_pay_ff, s4_pay_in;

   assign s4_dt_sh  = QUO_W'(s3_dt_ff) << TEMP_FRAC_BITS;
   assign s4_num0   = NUM0_W'(s4_dt_sh) * NUM0_W'(s3_dist_ff);
   assign s4_num_in = NUM_W'({s4_num0, 1'b0}) + NUM_W'(s3_span_ff);
   // a miss still flows through the divider; give it a harmless divisor
   assign s4_den_in = s3_hit_ff ? {s3_span_ff, 1'b0} : DEN_W'(1);
   assign s4_pay_in = {s3_hit_ff, QUO_W'(s3_tu_ff) << TEMP_FRAC_BITS};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (s4_en) begin
         s4_v_ff <= s3_v_ff;
      end
      if (s4_en) begin
         s4_num_ff <= s4_num_in;
         s4_den_ff <= s4_den_in;
         s4_pay_ff <= s4_pay_in;
      end
   end

   // ---------------------------------------------------------------------
   // rounded delta = (2*num + span) / (2*span), one bit per stage
   // ---------------------------------------------------------------------
   logic [QUO_W-1:0] div_quot;
   logic [PAY_W-1:0] div_pay;

   rtd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .QUO_W (QUO_W),
      .PAY_W (PAY_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s4_v_ff),
      .in_ready    (div_in_ready),
      .in_num      (s4_num_ff),
      .in_den      (s4_den_ff),
      .in_payload  (s4_pay_ff),
      .out_valid   (div_out_valid),
      .out_ready   (out_en),
      .out_quot    (div_quot),
      .out_payload (div_pay)
   );

   // ---------------------------------------------------------------------
   // output register: a miss reads zero, else upper temp minus delta, clamp at zero, saturate
   // ---------------------------------------------------------------------
   logic              rsp_v_ff;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic              rsp_hit_ff;
   logic [TW-1:0]     out_tu, out_delta, out_t;
   logic [TEMP_W-1:0] out_sat;

   assign out_tu      = TW'(div_pay[QUO_W-1:0]);
   assign out_delta   = TW'(div_quot);
   assign out_t       = (out_delta <= out_tu) ? (out_tu - out_delta) : '0;
   assign out_sat     = (out_t > TW'(TEMP_MAX)) ? TEMP_MAX : out_t[TEMP_W-1:0];
   assign rsp_temp_in = div_pay[QUO_W] ? out_sat : '0;

   assign out_en = !rsp_v_ff || rsp_tready;
   assign s4_en  = !s4_v_ff || div_in_ready;
   assign s3_en  = !s3_v_ff || s4_en;
   assign s2_en  = !s2_v_ff || s3_en;
   assign s1_en  = !s1_v_ff || s2_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_en) begin
         rsp_v_ff <= div_out_valid;
      end
      if (out_en) begin
         rsp_temp_ff <= rsp_temp_in;
         rsp_hit_ff  <= div_pay[QUO_W];
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, rsp_temp_ff};
   assign rsp_tuser  = rsp_hit_ff;

endmodule

FILE: design/rtd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_checker
// port-level checks on the converter, bound to the top level
// ----------------------------------------------------------------------------
module rtd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // words accepted but not yet delivered
   logic [7:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 8'd1;
      end else if (rsp_acc && !req_acc) begin
         pend_in = pend_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_result_after_reset : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word shown right after reset");

   a_no_invented_result : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pend_ff != 8'd0))
      else $error("result word without an accepted input word");

   a_miss_reads_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == 16'd0))
      else $error("out of range result carries a nonzero temperature");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result word changed");

endmodule

bind rtd_code_to_temperature rtd_checker u_rtd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
